/* hw/rtl/bsc_pkg.sv */
// Package for the byte substitution counter cipher.
// Holds item codes, register indexes, cipher constants and shared types.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package bsc_pkg;

  // Item kinds on the input channel.
  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_SEEK = 1'b1
  } kind_t;

  // Direction register codes.
  typedef enum logic [0:0] {
    DIR_DECRYPT = 1'b0,
    DIR_ENCRYPT = 1'b1
  } dir_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'b1;

  // Key schedule constants.
  localparam int          SCALE_SHIFT     = 10;
  localparam int          SCALED_W        = 32 - SCALE_SHIFT;
  localparam logic [21:0] STRIDE_LIMIT    = 22'd100;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for all 22-bit x.
  localparam logic [22:0] RECIP_100       = 23'd5368710;
  localparam int          RECIP_SHIFT     = 29;
  localparam int          RECIP_PROD_W    = 45;
  localparam logic [7:0]  STRIDE_ADD_ODD  = 8'd10;
  localparam logic [7:0]  STRIDE_ADD_EVEN = 8'd9;

  // Key counter constants.
  localparam logic [7:0]  COUNTER_INIT = 8'd127;
  localparam logic [7:0]  COUNTER_MAX  = 8'd255;
  localparam logic [7:0]  COUNTER_MIN  = 8'd1;
  localparam logic [31:0] SEEK_OFFSET  = 32'd126;
  localparam logic [8:0]  MOD_255      = 9'd255;

  // Key schedule sequencer states.
  typedef enum logic [1:0] {
    KG_IDLE,
    KG_DIV,
    KG_INV_MUL,
    KG_INV_FIX
  } kg_state_t;

  // One queued operation: a data byte, or the new counter of a seek.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } op_t;

  // Key material from the key schedule to the back end.
  // The forward table is base + i * stride; the inverse uses inv = 1/stride mod 256.
  typedef struct packed {
    logic       built;
    logic       busy;
    logic [7:0] base;
    logic [7:0] stride;
    logic [7:0] inv;
  } key_t;

  // Counter after a seek: (s + s/255 + 1) mod 256 reduces to (s mod 255) + 1,
  // since s = 255q + r gives 256q + r + 1. s mod 255 is the byte sum folded.
  function automatic logic [7:0] seek_counter(input logic [31:0] position);
    logic [31:0] s;
    logic [9:0]  sum;
    logic [8:0]  fold;
    s    = position + SEEK_OFFSET;
    sum  = 10'(s[7:0]) + 10'(s[15:8]) + 10'(s[23:16]) + 10'(s[31:24]);
    fold = 9'(sum[7:0]) + 9'(sum[9:8]);
    if (fold >= MOD_255) begin
      fold = fold - MOD_255;
    end
    return fold[7:0] + COUNTER_MIN;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsc_if.sv */
// Stream interfaces for the cipher: input items and result bytes.
// Depends on bsc_pkg for the item kind type.
`default_nettype none

interface bsc_item_if;
  logic               valid;
  logic               ready;
  bsc_pkg::kind_t     kind;
  logic [7:0]         data_byte;
  logic [31:0]        position;

  modport source (output valid, output kind, output data_byte, output position, input ready);
  modport sink   (input valid, input kind, input data_byte, input position, output ready);
endinterface

interface bsc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bsc_front.sv */
// Front end: accepts input items, classifies them and builds queue entries.
// Depends on bsc_pkg and bsc_item_if.
`default_nettype none

module bsc_front (
  bsc_item_if.sink       items,
  input  var logic       q_full,
  input  var logic       kg_busy,
  output bsc_pkg::op_t   push_op,
  output logic           push
);
  import bsc_pkg::*;

  // Hold off items while the queue is full or the key schedule runs.
  assign items.ready = !q_full && !kg_busy;
  assign push        = items.valid && items.ready;

  // A seek carries its new counter value; a data item carries its byte.
  always_comb begin
    push_op.kind = items.kind;
    case (items.kind)
      KIND_SEEK: push_op.value = seek_counter(items.position);
      KIND_DATA: push_op.value = items.data_byte;
      default:   push_op.value = items.data_byte;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bsc_queue.sv */
// Short queue of operations between the front and back ends.
// Depends on bsc_pkg for the entry type.
`default_nettype none

module bsc_queue #(
  parameter int DEPTH = 2
) (
  input  var logic         clk,
  input  var logic         rst,
  input  var logic         push,
  input  bsc_pkg::op_t     push_op,
  input  var logic         pop,
  output bsc_pkg::op_t     head_op,
  output logic             head_valid,
  output logic             full
);
  import bsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_op    = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

/* hw/rtl/bsc_keygen.sv */
// Key schedule: derives table base, stride and inverse stride from file_length.
// Depends on bsc_pkg for constants, the sequencer states and key_t.
`default_nettype none

module bsc_keygen (
  input  var logic                           clk,
  input  var logic                           rst,
  input  var logic                           cfg_we,
  input  var logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  var logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bsc_pkg::key_t                      key
);
  import bsc_pkg::*;

  kg_state_t               state;
  kg_state_t               state_next;
  logic                    built;
  logic [7:0]              base;
  logic [SCALED_W-1:0]     scaled;
  logic [7:0]              stride;
  logic [7:0]              inv;
  logic [7:0]              check;
  logic                    iter;
  logic                    start;
  logic [31:0]             seed;
  logic [RECIP_PROD_W-1:0] quot_prod;
  logic [SCALED_W-1:0]     quot;

  assign start     = cfg_we && (cfg_index == REG_FILE_LENGTH);
  assign seed      = cfg_data - 32'd1;
  // One division by 100 per cycle through the reciprocal.
  assign quot_prod = RECIP_PROD_W'(scaled) * RECIP_PROD_W'(RECIP_100);
  assign quot      = SCALED_W'(quot_prod[RECIP_PROD_W-1:RECIP_SHIFT]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      KG_IDLE:    if (start) state_next = KG_DIV;
      KG_DIV:     if (scaled <= STRIDE_LIMIT) state_next = KG_INV_MUL;
      KG_INV_MUL: state_next = KG_INV_FIX;
      KG_INV_FIX: state_next = iter ? KG_IDLE : KG_INV_MUL;
      default:    state_next = KG_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    key.built  = built;
    key.base   = base;
    key.stride = stride;
    key.inv    = inv;
    case (state)
      KG_IDLE: key.busy = 1'b0;
      default: key.busy = 1'b1;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KG_IDLE;
      built <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        built <= 1'b1;
      end
    end
  end

  // Datapath: scale down, make the stride odd, then two Newton steps for 1/stride.
  always_ff @(posedge clk) begin
    case (state)
      KG_IDLE: begin
        if (start) begin
          base   <= seed[7:0];
          scaled <= seed[31:SCALE_SHIFT];
        end
      end
      KG_DIV: begin
        if (scaled > STRIDE_LIMIT) begin
          scaled <= quot;
        end else begin
          // An odd start is already its own inverse modulo 8.
          stride <= scaled[7:0] + (scaled[0] ? STRIDE_ADD_ODD : STRIDE_ADD_EVEN);
          inv    <= scaled[7:0] + (scaled[0] ? STRIDE_ADD_ODD : STRIDE_ADD_EVEN);
          iter   <= 1'b0;
        end
      end
      KG_INV_MUL: begin
        check <= 8'(stride * inv);
      end
      KG_INV_FIX: begin
        inv  <= 8'(inv * (8'd2 - check));
        iter <= 1'b1;
      end
      default: begin
        iter <= 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bsc_back.sv */
// Back end: applies the substitution, steps the key counter and holds the result.
// Depends on bsc_pkg and bsc_result_if.
`default_nettype none

module bsc_back (
  input  var logic                           clk,
  input  var logic                           rst,
  input  var logic                           cfg_we,
  input  var logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  var logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  bsc_pkg::key_t                      key,
  input  bsc_pkg::op_t                       head_op,
  input  var logic                           head_valid,
  output logic                               pop,
  bsc_result_if.source                       results
);
  import bsc_pkg::*;

  logic [7:0]  counter;
  dir_t        direction;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [7:0]  inv_idx;
  logic [15:0] inv_prod;
  logic [7:0]  inv_entry;
  logic [7:0]  fwd_idx;
  logic [15:0] fwd_prod;
  logic [7:0]  fwd_entry;
  logic [7:0]  sub_byte;
  logic        is_data;

  assign is_data = (head_op.kind == KIND_DATA);
  // A seek never waits on the output register.
  assign pop = head_valid && (!is_data || !out_valid || results.ready);

  // Table lookups through the affine form; unbuilt tables read as zero.
  assign inv_idx   = head_op.value - key.base;
  assign inv_prod  = 16'(inv_idx) * 16'(key.inv);
  assign inv_entry = key.built ? inv_prod[7:0] : 8'd0;
  assign fwd_idx   = ~head_op.value ^ counter;
  assign fwd_prod  = 16'(fwd_idx) * 16'(key.stride);
  assign fwd_entry = key.built ? (key.base + fwd_prod[7:0]) : 8'd0;

  always_comb begin
    case (direction)
      DIR_ENCRYPT: sub_byte = fwd_entry;
      DIR_DECRYPT: sub_byte = ~(counter ^ inv_entry);
      default:     sub_byte = ~(counter ^ inv_entry);
    endcase
  end

  // Key counter and direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= COUNTER_INIT;
      direction <= DIR_DECRYPT;
    end else if (cfg_we && (cfg_index == REG_FILE_LENGTH)) begin
      counter <= COUNTER_INIT;
    end else if (cfg_we && (cfg_index == REG_DIRECTION)) begin
      direction <= dir_t'(cfg_data[0]);
    end else if (pop) begin
      if (is_data) begin
        counter <= (counter == COUNTER_MAX) ? COUNTER_MIN : counter + 8'd1;
      end else begin
        counter <= head_op.value;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_data) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_data) begin
      out_byte <= sub_byte;
    end
  end

  assign results.valid       = out_valid;
  assign results.result_byte = out_byte;

endmodule

`default_nettype wire

/* hw/rtl/byte_substitution_counter_cipher.sv */
// Top level of the byte substitution counter cipher.
// Depends on bsc_pkg, bsc_if, bsc_front, bsc_queue, bsc_keygen and bsc_back.
//
//   Channel   Dir  Handshake       Carries
//   items     in   valid/ready     kind, data_byte, position
//   results   out  valid/ready     result_byte
//   cfg       in   cfg_we only     cfg_index, cfg_data (file_length, direction)
//
// Items are taken at most one per cycle, while the queue has room and no key schedule
// runs; a data byte passes the queue and the output register before it is offered on
// results, a seek takes effect as it leaves the queue. A file_length write runs the key
// schedule (up to three divisions by 100, then the inverse); items are held off meanwhile.
// Reset is synchronous: counter 127, direction decrypt, tables read as zero.
// The queue lets the input keep flowing for a while during an output stall.
`default_nettype none

module byte_substitution_counter_cipher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  var logic                           clk,
  input  var logic                           rst,
  input  var logic                           cfg_we,
  input  var logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  var logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
  bsc_item_if.sink                           items,
  bsc_result_if.source                       results
);
  import bsc_pkg::*;

  op_t  push_op;
  logic push;
  op_t  head_op;
  logic head_valid;
  logic q_full;
  logic pop;
  key_t key;

  bsc_front u_front (
    .items   (items),
    .q_full  (q_full),
    .kg_busy (key.busy),
    .push_op (push_op),
    .push    (push)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_op    (head_op),
    .head_valid (head_valid),
    .full       (q_full)
  );

  bsc_keygen u_keygen (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  bsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key        (key),
    .head_op    (head_op),
    .head_valid (head_valid),
    .pop        (pop),
    .results    (results)
  );

endmodule

`default_nettype wire

/* hw/rtl/bsc_checker.sv */
// Port-level checks for the cipher top level, attached by a bind.
// Depends on bsc_pkg for the register index of file_length.
`default_nettype none

module bsc_checker (
  input var logic                          clk,
  input var logic                          rst,
  input var logic                          cfg_we,
  input var logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input var logic                          in_ready,
  input var logic                          out_valid,
  input var logic                          out_ready,
  input var logic [7:0]                    out_byte
);
  import bsc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its byte.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result byte changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // A length write starts the key schedule, which holds off input.
  a_rebuild_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_FILE_LENGTH) |=> !in_ready)
    else $error("input taken while tables rebuild");

endmodule

bind byte_substitution_counter_cipher bsc_checker u_bsc_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_byte  (results.result_byte)
);

`default_nettype wire

/* dv/byte_substitution_counter_cipher_tb.sv */
// Testbench for the byte substitution counter cipher: directed and random byte and seek
// traffic with scoreboarding against a behavioral key schedule and counter predictor.
// Depends on bsc_pkg, bsc_if and the byte_substitution_counter_cipher top level.
`default_nettype none

module byte_substitution_counter_cipher_tb;
  import bsc_pkg::*;

  localparam int CLK_PERIOD     = 20;
  // Covers the key schedule after a length write and the data pipeline.
  localparam int SETTLE_CYCLES  = 10;
  localparam int LONG_HOLD      = 60;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int TIMEOUT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bsc_item_if   items ();
  bsc_result_if results ();

  byte_substitution_counter_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted cipher state.
  logic [7:0] fwd_sub [256];
  logic [7:0] inv_sub [256];
  logic [7:0] key_ctr;
  dir_t       cipher_dir;

  logic [7:0] expected_bytes [$];

  // Traffic shaping controls shared with the result sink.
  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold_req;

  int mismatches;
  int data_sent;
  int seeks_sent;
  int results_seen;
  int length_writes;
  int long_holds;

  // Key schedule: seed is length minus one, odd stride from the scaled seed.
  function automatic void rebuild_key(logic [31:0] length);
    logic [31:0] seed;
    logic [31:0] scaled;
    logic [7:0]  stride;
    logic [7:0]  v;
    seed   = length - 32'd1;
    scaled = seed >> 10;
    while (scaled > 32'd100) begin
      scaled = scaled / 32'd100;
    end
    stride = scaled[0] ? 8'(scaled + 32'd10) : 8'(scaled + 32'd9);
    v = seed[7:0];
    for (int i = 0; i < 256; i++) begin
      fwd_sub[i] = v;
      inv_sub[v] = 8'(i);
      v = v + stride;
    end
    key_ctr = COUNTER_INIT;
  endfunction

  // Result of one data byte; the counter steps through 1..255 afterwards.
  function automatic logic [7:0] predict_byte(logic [7:0] b);
    logic [7:0] r;
    if (cipher_dir == DIR_ENCRYPT) begin
      r = fwd_sub[~b ^ key_ctr];
    end else begin
      r = ~(key_ctr ^ inv_sub[b]);
    end
    key_ctr = (key_ctr == COUNTER_MAX) ? COUNTER_MIN : key_ctr + 8'd1;
    return r;
  endfunction

  // Counter after a seek, in wrapping 32-bit arithmetic.
  function automatic void seek_to(logic [31:0] position);
    logic [31:0] s;
    s = position + SEEK_OFFSET;
    key_ctr = 8'(s + s / 32'd255 + 32'd1);
  endfunction

  function automatic void log_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch, %s: expected 0x%02h, got 0x%02h", what, want, got);
    end
  endfunction

  // Scoreboard: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        log_mismatch("result with nothing outstanding", 8'h00, results.result_byte);
      end else begin
        logic [7:0] want;
        want = expected_bytes.pop_front();
        if (results.result_byte !== want) begin
          log_mismatch("result_byte", want, results.result_byte);
        end
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    results.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        results.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_req = 1'b0;
        long_holds++;
        results.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 7);
        results.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        results.ready <= 1'b1;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Offers one item, waits for its transfer and records the prediction.
  task automatic send_item(kind_t kind, logic [7:0] data_byte, logic [31:0] position);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid     <= 1'b1;
    items.kind      <= kind;
    items.data_byte <= data_byte;
    items.position  <= position;
    do @(posedge clk); while (items.ready !== 1'b1);
    if (kind == KIND_SEEK) begin
      seek_to(position);
      seeks_sent++;
    end else begin
      expected_bytes.push_back(predict_byte(data_byte));
      data_sent++;
    end
  endtask

  task automatic send_data(logic [7:0] data_byte);
    send_item(KIND_DATA, data_byte, $urandom());
  endtask

  task automatic send_seek(logic [31:0] position);
    send_item(KIND_SEEK, 8'($urandom()), position);
  endtask

  // Waits until every result is back and the block has settled.
  task automatic wait_idle();
    items.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_FILE_LENGTH) begin
      rebuild_key(value);
      length_writes++;
    end else if (index == REG_DIRECTION) begin
      cipher_dir = dir_t'(value[0]);
    end
  endtask

  task automatic set_direction(dir_t dir);
    write_reg(REG_DIRECTION, {31'($urandom()), dir});
  endtask

  // Before any length write both tables read as zero.
  task automatic test_blank_tables();
    send_data(8'h00);
    send_data(8'hff);
    set_direction(DIR_ENCRYPT);
    send_data(8'h00);
    send_data(8'hff);
  endtask

  // Zero length wraps the seed; 102401 and 103425 sit on the stride scaling boundary.
  task automatic test_length_extremes();
    logic [31:0] lengths [5];
    lengths = '{32'd0, 32'd1, 32'hffff_ffff, 32'd102401, 32'd103425};
    foreach (lengths[i]) begin
      write_reg(REG_FILE_LENGTH, lengths[i]);
      set_direction(dir_t'(i[0]));
      send_data(8'h00);
      send_data(8'hff);
    end
  endtask

  // Seeks at the position extremes, one that wraps to zero, and a counter wrap.
  task automatic test_seek_cases();
    send_seek(32'h0000_0000);
    send_data(8'h5a);
    send_seek(32'hffff_ffff);
    send_seek(32'hffff_ff82);
    send_data(8'ha5);
    send_seek(32'd128);
    send_data(8'h3c);
    send_data(8'hc3);
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 6) == 0) begin
      send_seek($urandom());
    end else begin
      send_data(8'($urandom()));
    end
  endtask

  // Random phases, each with a fresh key and direction where drawn.
  task automatic test_random_traffic();
    logic [31:0] length;
    for (int phase = 0; phase < 7; phase++) begin
      src_idle_en  = (phase % 3) != 2;
      sink_idle_en = (phase % 3) != 1;
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: length = 32'd0;
          1: length = 32'hffff_ffff;
          2: length = $urandom_range(1, 1 << 20);
          default: length = $urandom();
        endcase
        write_reg(REG_FILE_LENGTH, length);
      end
      set_direction(dir_t'($urandom_range(0, 1)));
      repeat (200) send_random_item();
    end
    wait_idle();
  endtask

  // The sink holds off while the source keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(REG_FILE_LENGTH, $urandom());
    set_direction(DIR_DECRYPT);
    long_hold_req = 1'b1;
    repeat (50) send_data(8'($urandom()));
    wait_idle();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(REG_FILE_LENGTH, $urandom());
    set_direction(DIR_ENCRYPT);
    repeat (200) send_random_item();
  endtask

  initial begin : run
    int n;
    items.valid     <= 1'b0;
    items.kind      <= KIND_DATA;
    items.data_byte <= 8'h00;
    items.position  <= 32'h0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_FILE_LENGTH;
    cfg_data        <= '0;
    foreach (fwd_sub[i]) begin
      fwd_sub[i] = 8'h00;
      inv_sub[i] = 8'h00;
    end
    key_ctr    = COUNTER_INIT;
    cipher_dir = DIR_DECRYPT;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_blank_tables();
    test_length_extremes();
    test_seek_cases();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();

    // Drain with a bound, then settle.
    items.valid <= 1'b0;
    n = 0;
    while (expected_bytes.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0d expected result bytes never arrived", expected_bytes.size());
      mismatches += expected_bytes.size();
    end

    $display("Covered %0d data bytes and %0d seeks over %0d key rebuilds, %0d results checked.",
             data_sent, seeks_sent, length_writes, results_seen);
    $display("Both directions, blank tables, %0d long output hold-off(s), %0d mismatches.",
             long_holds, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
